### rtl/core/tmr_pkg.sv
// Shared types and constants for the token radix converter.
// No dependencies; imported by every module of the block except tmr_ram.
package tmr_pkg;

	localparam int MAX_DIGITS_DEF = 32;
	localparam int COUNT_CAP      = 32;

	localparam int CHAR_W   = 8;
	localparam int DIGIT_W  = 6;
	localparam int RADIX_W  = 6;
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 6;
	localparam int OUT_W    = 48;

	localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'd33;
	localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'd126;
	localparam logic [CHAR_W-1:0] CH_MINUS    = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO     = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE     = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UPPER_A  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UPPER_Z  = 8'h5A;
	localparam logic [CHAR_W-1:0] LETTER_BIAS = 8'd55;

	localparam logic [VALUE_W-1:0] LIMIT_POS = 32'h7FFF_FFFF;
	localparam logic [VALUE_W-1:0] LIMIT_NEG = 32'h8000_0000;

	typedef enum logic [3:0] {
		ST_COLLECT = 4'b0001,
		ST_PREP    = 4'b0010,
		ST_WALK    = 4'b0100,
		ST_EMIT    = 4'b1000
	} state_t;

	typedef struct packed {
		logic accept;
		logic prep;
		logic step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic fin_valid;
		logic held_zero;
		logic walk_last;
		logic out_free;
	} sts_t;

endpackage

### rtl/core/tmr_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module tmr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

### rtl/core/tmr_ctrl.sv
// Sequencer for the token radix converter: collect, prepare, walk, emit.
// Depends on tmr_pkg.
module tmr_ctrl import tmr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		unique case (state_q)
			ST_COLLECT: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && sts.fin_valid) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = sts.held_zero ? ST_EMIT : ST_WALK;
			end
			ST_WALK: begin
				cmd.step = 1'b1;
				if (sts.walk_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_COLLECT;
				end
			end
			default: state_d = ST_COLLECT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/core/tmr_dpath.sv
// Datapath: token scanning, digit store, multiply-accumulate walk, output register.
// Depends on tmr_pkg and tmr_ram.
module tmr_dpath import tmr_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [CHAR_W-1:0]  char_code,
	input  logic               stream_end,
	input  cmd_t               cmd,
	output sts_t               sts,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [OUT_W-1:0]   out_data,
	output logic               out_user
);

	localparam int AW = $clog2(MAX_DIGITS);
	localparam int CW = $clog2(MAX_DIGITS + 1);
	localparam int PW = VALUE_W + RADIX_W;

	logic [CW-1:0]      held_q;
	logic [DIGIT_W-1:0] largest_q;
	logic               in_tok_q;
	logic [1:0]         chars_q;
	logic               neg_q;
	logic               bad_q;
	logic               long_q;

	logic [CW-1:0]      ptr_q;
	logic [CW-1:0]      cnt_q;
	logic [VALUE_W-1:0] mag_q;
	logic               ovf_q;

	logic               out_vld_q;
	logic [OUT_W-1:0]   out_data_q;
	logic               out_user_q;

	logic               printable, is_minus, is_num, is_alpha, is_dig;
	logic [CHAR_W-1:0]  dig_wide;
	logic [DIGIT_W-1:0] dig;
	logic               store_it;
	logic [1:0]         chars_n;
	logic               neg_n, bad_n, in_tok_n;
	logic               finish, tok_ok;
	logic               wr_en;
	logic [DIGIT_W-1:0] rd_digit;

	logic [RADIX_W-1:0] radix;
	logic [VALUE_W-1:0] limit;
	logic [PW-1:0]      prod;
	logic [VALUE_W-1:0] mag_sat;
	logic [VALUE_W-1:0] value;
	logic [6:0]         held_ext;
	logic [COUNT_W-1:0] count_out;

	assign printable = (char_code >= CH_PRINT_LO) && (char_code <= CH_PRINT_HI);
	assign is_minus  = (char_code == CH_MINUS);
	assign is_num    = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign is_alpha  = (char_code >= CH_UPPER_A) && (char_code <= CH_UPPER_Z);
	assign is_dig    = is_num || is_alpha;
	assign dig_wide  = is_num ? (char_code - CH_ZERO) : (char_code - LETTER_BIAS);
	assign dig       = dig_wide[DIGIT_W-1:0];

	assign chars_n  = (chars_q < 2'd2) ? chars_q + 2'd1 : chars_q;
	assign neg_n    = neg_q || (is_minus && (chars_q == 2'd0));
	assign bad_n    = bad_q || (is_minus && (chars_q != 2'd0)) || (!is_minus && !is_dig);
	assign in_tok_n = printable ? 1'b1 : in_tok_q;

	assign finish = printable ? stream_end : (in_tok_q || stream_end);
	assign tok_ok = printable
		? (!bad_n && !(neg_n && (chars_n == 2'd1)))
		: (in_tok_q && !bad_q && !(neg_q && (chars_q == 2'd1)));

	assign store_it = printable && is_dig && !((dig == '0) && (held_q == '0));
	assign wr_en    = cmd.accept && store_it && (held_q < CW'(MAX_DIGITS));

	tmr_ram #(
		.WIDTH (DIGIT_W),
		.DEPTH (MAX_DIGITS)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (held_q[AW-1:0]),
		.wr_data (dig),
		.rd_addr (ptr_q[AW-1:0]),
		.rd_data (rd_digit)
	);

	assign radix   = (largest_q == '0) ? RADIX_W'(2) : largest_q + RADIX_W'(1);
	assign limit   = neg_q ? LIMIT_NEG : LIMIT_POS;
	assign prod    = PW'(mag_q) * PW'(radix) + PW'(rd_digit);
	assign mag_sat = ovf_q ? limit : mag_q;
	assign value   = neg_q ? (VALUE_W'(0) - mag_sat) : mag_sat;
	assign held_ext = 7'(held_q);
	assign count_out = (held_ext == 7'd0) ? COUNT_W'(1)
		: ((held_ext > 7'(COUNT_CAP)) ? COUNT_W'(COUNT_CAP) : held_ext[COUNT_W-1:0]);

	assign sts.fin_valid = finish && in_tok_n && tok_ok;
	assign sts.held_zero = (held_q == '0);
	assign sts.walk_last = (cnt_q == held_q - CW'(1));
	assign sts.out_free  = !out_vld_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q    <= '0;
			largest_q <= '0;
			in_tok_q  <= 1'b0;
			chars_q   <= '0;
			neg_q     <= 1'b0;
			bad_q     <= 1'b0;
			long_q    <= 1'b0;
			ptr_q     <= '0;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
		end else begin
			priority if (cmd.accept) begin
				if (finish && !(in_tok_n && tok_ok)) begin
					held_q    <= '0;
					largest_q <= '0;
					in_tok_q  <= 1'b0;
					chars_q   <= '0;
					neg_q     <= 1'b0;
					bad_q     <= 1'b0;
					long_q    <= 1'b0;
				end else if (printable) begin
					in_tok_q <= 1'b1;
					chars_q  <= chars_n;
					neg_q    <= neg_n;
					bad_q    <= bad_n;
					if (is_dig && (dig > largest_q)) begin
						largest_q <= dig;
					end
					if (store_it) begin
						if (held_q < CW'(MAX_DIGITS)) begin
							held_q <= held_q + CW'(1);
						end else begin
							long_q <= 1'b1;
						end
					end
				end
			end else if (cmd.prep) begin
				ptr_q <= CW'(1);
				cnt_q <= '0;
				ovf_q <= long_q;
			end else if (cmd.step) begin
				ptr_q <= ptr_q + CW'(1);
				cnt_q <= cnt_q + CW'(1);
				if (prod > PW'(limit)) begin
					ovf_q <= 1'b1;
				end
			end else if (cmd.emit) begin
				held_q    <= '0;
				largest_q <= '0;
				in_tok_q  <= 1'b0;
				chars_q   <= '0;
				neg_q     <= 1'b0;
				bad_q     <= 1'b0;
				long_q    <= 1'b0;
				ptr_q     <= '0;
				cnt_q     <= '0;
				ovf_q     <= 1'b0;
			end else begin
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			mag_q <= '0;
		end else if (cmd.step) begin
			if (prod > PW'(limit)) begin
				mag_q <= limit + VALUE_W'(1);
			end else begin
				mag_q <= prod[VALUE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.emit) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q <= {4'b0000, count_out, value, radix};
			out_user_q <= ovf_q;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;

endmodule

### rtl/core/token_min_radix_to_binary_top.sv
// Top level of the token radix converter: sequencer plus datapath.
// Depends on tmr_pkg, tmr_ctrl, tmr_dpath (and tmr_ram below it).
//
// Channel   Dir  Payload
// s_axis    in   tdata[7:0] char_code, tlast stream_end
// m_axis    out  tdata radix, value, digit_count; tuser overflowed
//
// Characters transfer one per cycle while a token is collected.
// A valid token's end runs a prepare step, one walk step per stored digit
// (the single multiply-accumulate over the digit RAM read port) and an
// emit step, with input held off; the walk is skipped when no digit is stored.
// A waiting result does not stop collection; only the emit cycle waits for m_axis_tready.
// Reset clears all control state; the digit RAM needs no clearing.
module token_min_radix_to_binary_top import tmr_pkg::*; #(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [7:0]        s_axis_tdata,   // [7:0] char_code
	input  logic              s_axis_tlast,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [OUT_W-1:0]  m_axis_tdata,   // [5:0] radix, [37:6] value, [43:38] digit_count
	output logic              m_axis_tuser    // [0] overflowed
);

	cmd_t cmd;
	sts_t sts;

	tmr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tmr_dpath #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_code  (s_axis_tdata),
		.stream_end (s_axis_tlast),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata),
		.out_user   (m_axis_tuser)
	);

endmodule

### tb/tb_token_min_radix_to_binary_top.sv
// Self-checking testbench for token_min_radix_to_binary_top: character stream in, one
// result per valid token out, checked against an in-bench token converter model.
// Depends on tmr_pkg and the block's RTL only.
module tb_token_min_radix_to_binary_top;
	import tmr_pkg::*;

	localparam int LIMIT_CYCLES = 500_000;
	localparam int ITEMS_PER_PHASE = 175;
	localparam int NUM_PHASES = 4;
	localparam int DRAIN_CYCLES = MAX_DIGITS_DEF + 8;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} char_beat_t;

	typedef struct packed {
		logic [RADIX_W-1:0]        radix;
		logic signed [VALUE_W-1:0] value;
		logic                      ovf;
		logic [COUNT_W-1:0]        ndig;
	} tok_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic m_axis_tuser;

	char_beat_t  pending_chars[$];
	tok_result_t expected_tokens[$];
	logic        in_took = 1'b0;
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int n_pushed = 0;
	int n_taken = 0;
	int n_tokens_out = 0;
	int n_saturated = 0;
	int n_faults = 0;
	int cycle_count = 0;

	// token converter state
	logic [DIGIT_W-1:0] dig_mem [MAX_DIGITS_DEF];
	int unsigned n_sig = 0;
	int unsigned top_digit = 0;
	bit          tok_open = 1'b0;
	int unsigned n_chars = 0;
	bit          tok_minus = 1'b0;
	bit          tok_broken = 1'b0;
	bit          tok_overlong = 1'b0;

	token_min_radix_to_binary_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit close_token(output tok_result_t res);
		longint unsigned mag, limit, rdx;
		bit ovf, got;
		logic [VALUE_W-1:0] val;
		got = 1'b0;
		res = '0;
		if (tok_open && !tok_broken && !(tok_minus && n_chars == 1)) begin
			rdx = (top_digit + 1 < 2) ? 2 : top_digit + 1;
			limit = tok_minus ? 64'h8000_0000 : 64'h7FFF_FFFF;
			mag = 0;
			ovf = tok_overlong;
			for (int i = 0; i < n_sig; i++) begin
				mag = mag * rdx + dig_mem[i];
				if (mag > limit) begin
					ovf = 1'b1;
					mag = limit + 1;
				end
			end
			if (ovf)
				mag = limit;
			val = tok_minus ? (32'd0 - mag[31:0]) : mag[31:0];
			res.radix = rdx[RADIX_W-1:0];
			res.value = val;
			res.ovf = ovf;
			res.ndig = (n_sig == 0) ? COUNT_W'(1) : n_sig[COUNT_W-1:0];
			got = 1'b1;
		end
		n_sig = 0;
		top_digit = 0;
		tok_open = 1'b0;
		n_chars = 0;
		tok_minus = 1'b0;
		tok_broken = 1'b0;
		tok_overlong = 1'b0;
		return got;
	endfunction

	function automatic bit convert_byte(input logic [7:0] c, input logic last,
			output tok_result_t res);
		int d;
		int unsigned pos;
		res = '0;
		if (c >= CH_PRINT_LO && c <= CH_PRINT_HI) begin
			pos = n_chars;
			tok_open = 1'b1;
			if (n_chars < 2)
				n_chars++;
			d = -1;
			if (c >= CH_ZERO && c <= CH_NINE)
				d = int'(c) - int'(CH_ZERO);
			else if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
				d = int'(c) - int'(CH_UPPER_A) + 10;
			if (c == CH_MINUS) begin
				if (pos == 0)
					tok_minus = 1'b1;
				else
					tok_broken = 1'b1;
			end else if (d < 0) begin
				tok_broken = 1'b1;
			end else begin
				if (d > top_digit)
					top_digit = d;
				if (!(d == 0 && n_sig == 0)) begin
					if (n_sig < MAX_DIGITS_DEF) begin
						dig_mem[n_sig] = d[DIGIT_W-1:0];
						n_sig++;
					end else begin
						tok_overlong = 1'b1;
					end
				end
			end
			if (last)
				return close_token(res);
			return 1'b0;
		end
		if (tok_open || last)
			return close_token(res);
		return 1'b0;
	endfunction

	function automatic logic [7:0] digit_char(int d);
		return (d < 10) ? 8'(int'(CH_ZERO) + d) : 8'(int'(CH_UPPER_A) + d - 10);
	endfunction

	function automatic logic [7:0] pick_gap();
		case ($urandom_range(0, 5))
			0: return 8'h20;
			1: return 8'h09;
			2: return 8'h0A;
			3: return 8'($urandom_range(0, 31));
			4: return 8'h7F;
			default: return 8'($urandom_range(128, 255));
		endcase
	endfunction

	task automatic add_byte(logic [7:0] c, logic last);
		char_beat_t b;
		b.code = c;
		b.last = last;
		pending_chars.push_back(b);
		n_pushed++;
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i], 1'b0);
	endtask

	task automatic add_random_token();
		logic [7:0] tok[$];
		logic [7:0] bad;
		int kind, rdx, len;
		bit ends_here;
		kind = $urandom_range(0, 99);
		if (kind < 58) begin
			rdx = $urandom_range(2, 36);
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 8);
			if ($urandom_range(0, 9) < 3)
				tok.push_back(CH_MINUS);
			if ($urandom_range(0, 1))
				repeat ($urandom_range(1, 3)) tok.push_back(CH_ZERO);
			repeat (len) tok.push_back(digit_char($urandom_range(0, rdx - 1)));
		end else if (kind < 70) begin
			if ($urandom_range(0, 1))
				tok.push_back(CH_MINUS);
			if ($urandom_range(0, 3) == 0)
				tok.push_back(CH_ZERO);
			case ($urandom_range(0, 3))
				0: begin
					tok.push_back(digit_char(1));
					repeat (31) tok.push_back(CH_ZERO);
				end
				1: repeat (31) tok.push_back(digit_char(1));
				2: repeat ($urandom_range(32, 34)) tok.push_back(digit_char(1));
				default: begin
					tok.push_back(digit_char(7));
					repeat (7) tok.push_back(digit_char(15));
				end
			endcase
		end else if (kind < 85) begin
			case ($urandom_range(0, 2))
				0: tok.push_back(CH_MINUS);
				1: begin
					repeat ($urandom_range(1, 4)) tok.push_back(digit_char($urandom_range(0, 35)));
					tok.insert($urandom_range(1, tok.size()), CH_MINUS);
				end
				default: begin
					repeat ($urandom_range(0, 4)) tok.push_back(digit_char($urandom_range(0, 35)));
					bad = 8'($urandom_range(33, 126));
					while ((bad >= CH_ZERO && bad <= CH_NINE) || bad == CH_MINUS ||
							(bad >= CH_UPPER_A && bad <= CH_UPPER_Z))
						bad = 8'($urandom_range(33, 126));
					tok.insert($urandom_range(0, tok.size()), bad);
				end
			endcase
		end else begin
			repeat ($urandom_range(1, 4))
				add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
			return;
		end
		ends_here = ($urandom_range(0, 99) < 15);
		foreach (tok[i])
			add_byte(tok[i], ends_here && i == tok.size() - 1);
		if (!ends_here)
			add_byte(pick_gap(), $urandom_range(0, 9) == 0);
	endtask

	always @(negedge clk) begin
		char_beat_t beat;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			m_axis_tready <= 1'b0;
		end else begin
			if (!s_axis_tvalid || in_took) begin
				if (pending_chars.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
					beat = pending_chars.pop_front();
					s_axis_tdata <= beat.code;
					s_axis_tlast <= beat.last;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		tok_result_t want, fresh;
		logic [RADIX_W-1:0] got_radix;
		logic signed [VALUE_W-1:0] got_value;
		logic [COUNT_W-1:0] got_count;
		if (arst_n) begin
			cycle_count++;
			if (m_axis_tvalid && m_axis_tready) begin
				got_radix = m_axis_tdata[5:0];
				got_value = m_axis_tdata[37:6];
				got_count = m_axis_tdata[43:38];
				if (expected_tokens.size() == 0) begin
					$error("result with no token pending: tdata %h tuser %b",
						m_axis_tdata, m_axis_tuser);
					n_faults++;
				end else begin
					want = expected_tokens.pop_front();
					if (got_radix !== want.radix) begin
						$error("radix: expected %0d, got %0d", want.radix, got_radix);
						n_faults++;
					end
					if (got_value !== want.value) begin
						$error("value: expected %0d, got %0d", want.value, got_value);
						n_faults++;
					end
					if (m_axis_tuser !== want.ovf) begin
						$error("overflowed: expected %0d, got %0d", want.ovf, m_axis_tuser);
						n_faults++;
					end
					if (got_count !== want.ndig) begin
						$error("digit_count: expected %0d, got %0d", want.ndig, got_count);
						n_faults++;
					end
					n_tokens_out++;
					if (m_axis_tuser === 1'b1)
						n_saturated++;
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				n_taken++;
				if (convert_byte(s_axis_tdata, s_axis_tlast, fresh))
					expected_tokens.push_back(fresh);
			end
			in_took <= s_axis_tvalid && s_axis_tready;
		end
	end

	initial begin
		wait (cycle_count >= LIMIT_CYCLES);
		$display("token_min_radix_to_binary_top: mismatch");
		$finish;
	end

	initial begin
		int src_pct [NUM_PHASES];
		int sink_pct [NUM_PHASES];
		src_pct = '{0, 59, 0, 27};
		sink_pct = '{0, 0, 59, 27};

		// corner tokens: zeros, lone and misplaced minus, bad characters, extremes
		add_text("0");
		add_byte(8'h20, 1'b0);
		add_text("-00");
		add_byte(8'h09, 1'b0);
		add_text("-");
		add_byte(8'h20, 1'b0);
		add_text("1-2");
		add_byte(8'h0A, 1'b0);
		add_text("a");
		add_byte(8'h7F, 1'b0);
		add_text("!~");
		add_byte(8'h80, 1'b0);
		add_text("Z");
		add_byte(8'hFF, 1'b0);
		add_text("-");
		add_byte("Z", 1'b1);
		add_byte(8'h00, 1'b1);
		add_text("0");
		add_byte("9", 1'b1);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < NUM_PHASES; p++) begin
			@(posedge clk);
			src_idle_pct = src_pct[p];
			sink_stall_pct = sink_pct[p];
			while (n_pushed < ITEMS_PER_PHASE * (p + 1))
				add_random_token();
			add_byte(8'h20, 1'b1);
			// hold off further input until every token result has drained
			do
				@(negedge clk);
			while (n_taken != n_pushed || expected_tokens.size() != 0);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_tokens.size() != 0) begin
			$error("%0d token results never arrived", expected_tokens.size());
			n_faults++;
		end

		$display("Sent %0d characters over %0d pacing phases (free-running, source gaps,",
			n_taken, NUM_PHASES);
		$display("sink stalls, both); checked %0d token results, %0d of them saturated.",
			n_tokens_out, n_saturated);
		if (n_faults == 0)
			$display("token_min_radix_to_binary_top: match");
		else
			$display("token_min_radix_to_binary_top: mismatch");
		$finish;
	end

endmodule
